/* hw/rtl/sd_spi_host_transaction_engine_macros.svh */
// Assertion macros used by the engine's core RTL file.
`ifndef SD_SPI_HOST_TRANSACTION_ENGINE_MACROS_SVH
`define SD_SPI_HOST_TRANSACTION_ENGINE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SSH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define SSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ssh_pkg.sv */
// ----------------------------------------------------------------------------
// ssh_pkg
// Types, constants and CRC functions of the SD SPI-mode host engine.
// ----------------------------------------------------------------------------
package ssh_pkg;

	localparam int WriteBlockBytesDef = 512;
	localparam int ResponsePollsDef   = 8;
	localparam int MaxReadBytesDef    = 1024;

	localparam int WaitW  = 20;
	localparam int CountW = 13;
	localparam int PollW  = 4;
	localparam int AddrW  = 3;

	localparam logic [WaitW-1:0] WaitMax        = 20'hFFFFF;
	localparam logic [WaitW-1:0] TokenWaitReset = 20'd100;
	localparam logic [WaitW-1:0] BusyWaitReset  = 20'd500;

	localparam logic [7:0] ByteIdle       = 8'hFF;
	localparam logic [7:0] TokenStart     = 8'hFE;
	localparam logic [3:0] DataAccepted   = 4'h5;

	localparam logic [AddrW-1:0] RegTokenWait = 3'd0;
	localparam logic [AddrW-1:0] RegBusyWait  = 3'd4;

	localparam logic [1:0] FuncStart = 2'd0;
	localparam logic [1:0] FuncXfer  = 2'd1;
	localparam logic [1:0] FuncTick  = 2'd2;

	localparam logic [1:0] OpCmd   = 2'd0;
	localparam logic [1:0] OpRead  = 2'd1;
	localparam logic [1:0] OpWrite = 2'd2;

	localparam logic [1:0] KindNone = 2'd0;
	localparam logic [1:0] KindResp = 2'd1;
	localparam logic [1:0] KindData = 2'd2;

	typedef enum logic [12:0] {
		PH_IDLE    = 13'b0000000000001,
		PH_FRAME   = 13'b0000000000010,
		PH_R1      = 13'b0000000000100,
		PH_RESP    = 13'b0000000001000,
		PH_TOKEN   = 13'b0000000010000,
		PH_RDATA   = 13'b0000000100000,
		PH_WSTART  = 13'b0000001000000,
		PH_WDATA   = 13'b0000010000000,
		PH_WCRC    = 13'b0000100000000,
		PH_WRESP   = 13'b0001000000000,
		PH_BUSY    = 13'b0010000000000,
		PH_END_OK  = 13'b0100000000000,
		PH_END_ERR = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  op;
		logic [5:0]  cmd_index;
		logic [31:0] argument;
		logic [2:0]  resp_len;
		logic [10:0] block_len;
		logic [7:0]  miso_byte;
		logic [7:0]  write_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] mosi_byte;
		logic       send_valid;
		logic       deselect_after;
		logic [7:0] rx_byte;
		logic [1:0] rx_kind;
		logic       done_res;
		logic       status;
	} res_t;

	typedef struct packed {
		logic [WaitW-1:0] token_wait_ticks;
		logic [WaitW-1:0] busy_wait_ticks;
	} cfg_t;

	function automatic logic [6:0] crc7_feed(logic [6:0] acc, logic [7:0] b);
		logic [7:0] c;
		c = {acc, 1'b0} ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) c = c ^ 8'h89;
			c = {c[6:0], 1'b0};
		end
		return c[7:1];
	endfunction

	function automatic logic [15:0] crc16_feed(logic [15:0] acc, logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ 16'h1021;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

/* hw/rtl/ssh_stream_if.sv */
// ----------------------------------------------------------------------------
// ssh_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface ssh_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ssh_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ssh_cfg_regs
// APB register file holding the token and busy wait limits.
// ----------------------------------------------------------------------------
module ssh_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ssh_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output ssh_pkg::cfg_t             cfg
);
	logic [ssh_pkg::WaitW-1:0] token_q;
	logic [ssh_pkg::WaitW-1:0] busy_q;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= ssh_pkg::TokenWaitReset;
			busy_q  <= ssh_pkg::BusyWaitReset;
		end else if (wr_en) begin
			case (paddr)
				ssh_pkg::RegTokenWait: token_q <= pwdata[ssh_pkg::WaitW-1:0];
				ssh_pkg::RegBusyWait:  busy_q  <= pwdata[ssh_pkg::WaitW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ssh_pkg::RegTokenWait: prdata = {12'd0, token_q};
			ssh_pkg::RegBusyWait:  prdata = {12'd0, busy_q};
			default:               prdata = 32'd0;
		endcase
	end

	assign cfg.token_wait_ticks = token_q;
	assign cfg.busy_wait_ticks  = busy_q;
endmodule

/* hw/rtl/ssh_core.sv */
// ----------------------------------------------------------------------------
// ssh_core
// Transaction FSM: one request in, at most one result out per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "sd_spi_host_transaction_engine_macros.svh"

module ssh_core #(
	parameter int WRITE_BLOCK_BYTES = ssh_pkg::WriteBlockBytesDef,
	parameter int RESPONSE_POLLS    = ssh_pkg::ResponsePollsDef,
	parameter int MAX_READ_BYTES    = ssh_pkg::MaxReadBytesDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ssh_pkg::cfg_t cfg,
	ssh_stream_if.sink    req,
	ssh_stream_if.source  res
);
	localparam int CW = ssh_pkg::CountW;

	ssh_pkg::phase_t           phase_q, phase_d;
	logic [1:0]                op_q, op_d;
	logic [31:0]               arg_q, arg_d;
	logic [CW-1:0]             cnt_q, cnt_d;
	logic [ssh_pkg::PollW-1:0] poll_q, poll_d;
	logic [ssh_pkg::WaitW-1:0] wait_q, wait_d;
	logic [6:0]                crc7_q, crc7_d;
	logic [15:0]               crc16_q, crc16_d;
	logic [2:0]                rem_q, rem_d;
	logic [CW-1:0]             rlen_q, rlen_d;

	logic                      out_valid_q;
	ssh_pkg::res_t             out_q, r;
	logic                      emit;
	logic                      take;
	ssh_pkg::req_t             in;
	logic [7:0]                b0, m, wb, argb;
	logic [2:0]                rl;
	logic [CW-1:0]             bl, cnt_inc;
	logic [1:0]                opn;

	assign in   = req.data;
	assign m    = in.miso_byte;
	assign wb   = in.write_byte;
	assign take = req.valid && req.ready;
	assign req.ready = !out_valid_q || res.ready;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;
	assign cnt_inc   = cnt_q + CW'(1);

	always_comb begin
		phase_d = phase_q; op_d = op_q; arg_d = arg_q; cnt_d = cnt_q;
		poll_d = poll_q; wait_d = wait_q; crc7_d = crc7_q; crc16_d = crc16_q;
		rem_d = rem_q; rlen_d = rlen_q;
		emit = 1'b0;
		r = '0;
		b0 = {2'b01, in.cmd_index};
		rl = (in.resp_len == 3'd0) ? 3'd1 : ((in.resp_len > 3'd5) ? 3'd5 : in.resp_len);
		bl = (in.block_len == 11'd0) ? CW'(1) :
			((CW'(in.block_len) > CW'(MAX_READ_BYTES)) ? CW'(MAX_READ_BYTES)
				: CW'(in.block_len));
		opn = (in.op == 2'd3) ? ssh_pkg::OpCmd : in.op;
		case (cnt_q[1:0])
			2'd0: argb = arg_q[31:24];
			2'd1: argb = arg_q[23:16];
			2'd2: argb = arg_q[15:8];
			default: argb = arg_q[7:0];
		endcase
		case (in.func)
			ssh_pkg::FuncStart: begin
				if (phase_q == ssh_pkg::PH_IDLE) begin
					emit = 1'b1;
					op_d = opn;
					arg_d = in.argument;
					rem_d = (opn == ssh_pkg::OpCmd) ? rl - 3'd1 : 3'd0;
					rlen_d = bl;
					crc16_d = '0; poll_d = '0; wait_d = '0;
					crc7_d = ssh_pkg::crc7_feed(7'd0, b0);
					cnt_d = '0;
					phase_d = ssh_pkg::PH_FRAME;
					r.mosi_byte = b0; r.send_valid = 1'b1;
				end
			end
			ssh_pkg::FuncTick: begin
				if ((phase_q == ssh_pkg::PH_TOKEN || phase_q == ssh_pkg::PH_BUSY)
						&& wait_q != ssh_pkg::WaitMax)
					wait_d = wait_q + ssh_pkg::WaitW'(1);
			end
			ssh_pkg::FuncXfer: begin
				emit = (phase_q != ssh_pkg::PH_IDLE);
				r.send_valid = 1'b1;
				r.mosi_byte = ssh_pkg::ByteIdle;
				case (phase_q)
					ssh_pkg::PH_FRAME: begin
						if (cnt_q < CW'(4)) begin
							cnt_d = cnt_inc;
							r.mosi_byte = argb;
							crc7_d = ssh_pkg::crc7_feed(crc7_q, argb);
						end else if (cnt_q == CW'(4)) begin
							cnt_d = CW'(5);
							r.mosi_byte = {crc7_q, 1'b1};
						end else begin
							phase_d = ssh_pkg::PH_R1;
							poll_d = ssh_pkg::PollW'(1);
						end
					end
					ssh_pkg::PH_R1: begin
						if (m[7] && poll_q < ssh_pkg::PollW'(RESPONSE_POLLS)) begin
							poll_d = poll_q + ssh_pkg::PollW'(1);
						end else begin
							r.rx_byte = m; r.rx_kind = ssh_pkg::KindResp;
							if (op_q == ssh_pkg::OpRead) begin
								if (m != 8'd0) begin
									phase_d = ssh_pkg::PH_IDLE;
									r.send_valid = 1'b0; r.mosi_byte = '0;
									r.done_res = 1'b1; r.status = 1'b1;
								end else begin
									phase_d = ssh_pkg::PH_TOKEN;
									wait_d = '0;
								end
							end else if (op_q == ssh_pkg::OpWrite) begin
								phase_d = ssh_pkg::PH_WSTART;
								r.mosi_byte = ssh_pkg::TokenStart;
							end else if (rem_q != 3'd0) begin
								phase_d = ssh_pkg::PH_RESP;
							end else begin
								phase_d = ssh_pkg::PH_END_OK;
								r.deselect_after = 1'b1;
							end
						end
					end
					ssh_pkg::PH_RESP: begin
						rem_d = rem_q - 3'd1;
						r.rx_byte = m; r.rx_kind = ssh_pkg::KindResp;
						if (rem_q == 3'd1) begin
							phase_d = ssh_pkg::PH_END_OK;
							r.deselect_after = 1'b1;
						end
					end
					ssh_pkg::PH_END_OK, ssh_pkg::PH_END_ERR: begin
						phase_d = ssh_pkg::PH_IDLE;
						r.send_valid = 1'b0; r.mosi_byte = '0;
						r.done_res = 1'b1;
						r.status = (phase_q == ssh_pkg::PH_END_ERR);
					end
					ssh_pkg::PH_TOKEN: begin
						if (m == ssh_pkg::TokenStart) begin
							phase_d = ssh_pkg::PH_RDATA;
							cnt_d = '0;
							r.deselect_after = (rlen_q == CW'(1));
						end else if (m[7:4] == 4'd0 || wait_q >= cfg.token_wait_ticks) begin
							phase_d = ssh_pkg::PH_IDLE;
							r.send_valid = 1'b0; r.mosi_byte = '0;
							r.done_res = 1'b1; r.status = 1'b1;
							if (m[7:4] == 4'd0) begin
								r.rx_byte = m; r.rx_kind = ssh_pkg::KindResp;
							end
						end
					end
					ssh_pkg::PH_RDATA: begin
						cnt_d = cnt_inc;
						r.rx_byte = m; r.rx_kind = ssh_pkg::KindData;
						if (cnt_inc >= rlen_q) begin
							phase_d = ssh_pkg::PH_IDLE;
							r.send_valid = 1'b0; r.mosi_byte = '0;
							r.done_res = 1'b1;
						end else begin
							r.deselect_after = (cnt_inc + CW'(1) == rlen_q);
						end
					end
					ssh_pkg::PH_WSTART: begin
						crc16_d = ssh_pkg::crc16_feed(16'd0, wb);
						cnt_d = CW'(1);
						phase_d = ssh_pkg::PH_WDATA;
						r.mosi_byte = wb;
					end
					ssh_pkg::PH_WDATA: begin
						if (cnt_q < CW'(WRITE_BLOCK_BYTES)) begin
							crc16_d = ssh_pkg::crc16_feed(crc16_q, wb);
							cnt_d = cnt_inc;
							r.mosi_byte = wb;
						end else begin
							phase_d = ssh_pkg::PH_WCRC;
							cnt_d = '0;
							r.mosi_byte = crc16_q[15:8];
						end
					end
					ssh_pkg::PH_WCRC: begin
						if (cnt_q == '0) begin
							cnt_d = CW'(1);
							r.mosi_byte = crc16_q[7:0];
						end else begin
							phase_d = ssh_pkg::PH_WRESP;
							poll_d = ssh_pkg::PollW'(1);
						end
					end
					ssh_pkg::PH_WRESP: begin
						if (m[4] && poll_q < ssh_pkg::PollW'(RESPONSE_POLLS)) begin
							poll_d = poll_q + ssh_pkg::PollW'(1);
						end else begin
							r.rx_byte = m; r.rx_kind = ssh_pkg::KindResp;
							if (m[3:0] == ssh_pkg::DataAccepted) begin
								phase_d = ssh_pkg::PH_BUSY;
								wait_d = '0;
							end else begin
								phase_d = ssh_pkg::PH_END_ERR;
								r.deselect_after = 1'b1;
							end
						end
					end
					ssh_pkg::PH_BUSY: begin
						if (m != 8'd0 || wait_q >= cfg.busy_wait_ticks) begin
							phase_d = ssh_pkg::PH_END_OK;
							r.deselect_after = 1'b1;
						end
					end
					default: begin
						r = '0;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ssh_pkg::PH_IDLE;
			op_q <= '0; arg_q <= '0; cnt_q <= '0; poll_q <= '0; wait_q <= '0;
			crc7_q <= '0; crc16_q <= '0; rem_q <= '0; rlen_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d; op_q <= op_d; arg_q <= arg_d; cnt_q <= cnt_d;
				poll_q <= poll_d; wait_q <= wait_d; crc7_q <= crc7_d;
				crc16_q <= crc16_d; rem_q <= rem_d; rlen_q <= rlen_d;
			end
			if (req.ready) out_valid_q <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) out_q <= r;
	end

	`SSH_ASSERT_IMP(a_hold_stall, clk, arst_n, res.valid && !res.ready, !req.ready, "request taken while result stalled")
	`SSH_ASSERT_NEXT(a_done_idle, clk, arst_n, take && emit && r.done_res, phase_q == ssh_pkg::PH_IDLE, "done without return to idle")
	`SSH_ASSERT_IMP(a_poll_range, clk, arst_n, 1'b1, poll_q <= ssh_pkg::PollW'(RESPONSE_POLLS), "poll count beyond limit")
	`SSH_ASSERT_IMP(a_send_or_done, clk, arst_n, res.valid, res.data.send_valid != res.data.done_res, "result neither sends nor ends")
endmodule

/* hw/rtl/sd_spi_host_transaction_engine.sv */
// Each request (start, byte exchange done, or timer tick) is taken on a valid
// and ready handshake; its result, if any, appears in the output register on
// the next cycle. A new request is accepted every cycle while the result
// register is free or being drained, so throughput is one request per cycle
// under that condition, with CRC7 and CRC16 updated a whole byte at a time.
// ----------------------------------------------------------------------------
// sd_spi_host_transaction_engine
// SD card SPI-mode command, block read and block write sequencer.
// ----------------------------------------------------------------------------
module sd_spi_host_transaction_engine #(
	parameter int WRITE_BLOCK_BYTES = ssh_pkg::WriteBlockBytesDef,
	parameter int RESPONSE_POLLS    = ssh_pkg::ResponsePollsDef,
	parameter int MAX_READ_BYTES    = ssh_pkg::MaxReadBytesDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ssh_stream_if.sink                req,
	ssh_stream_if.source              res,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ssh_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	ssh_pkg::cfg_t cfg;

	ssh_cfg_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	ssh_core #(
		.WRITE_BLOCK_BYTES(WRITE_BLOCK_BYTES),
		.RESPONSE_POLLS(RESPONSE_POLLS),
		.MAX_READ_BYTES(MAX_READ_BYTES)
	) u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .res(res)
	);
endmodule

/* verif/sd_spi_host_transaction_engine_checker.sv */
// ----------------------------------------------------------------------------
// sd_spi_host_transaction_engine_checker
// Watches the request, result and register channels of the SD SPI host
// engine. It keeps its own copy of the engine state, works out the result
// that each accepted request should give, and compares the results in order.
// ----------------------------------------------------------------------------
module sd_spi_host_transaction_engine_checker
	import ssh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req_data,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_t        res_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WriteBytes = WriteBlockBytesDef;
	localparam int Polls      = ResponsePollsDef;
	localparam int MaxRead    = MaxReadBytesDef;

	res_t expected_q[$];

	logic [WaitW-1:0] token_limit;
	logic [WaitW-1:0] busy_limit;

	phase_t      step;
	logic [1:0]  txn_op;
	logic [5:0]  txn_index;
	logic [31:0] txn_arg;
	int unsigned nbytes;
	int unsigned npolls;
	logic [WaitW-1:0] ticks;
	logic [6:0]  crc7;
	logic [15:0] crc16;
	int unsigned resp_left;
	int unsigned read_len;

	// Serial form of the command CRC, polynomial x^7 + x^3 + 1.
	function automatic logic [6:0] crc7_next(logic [6:0] a, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = a[6] ^ b[i];
			a = {a[5:0], 1'b0};
			if (fb) a = a ^ 7'h09;
		end
		return a;
	endfunction

	function automatic logic [15:0] crc16_next(logic [15:0] a, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = a[15] ^ b[i];
			a = {a[14:0], 1'b0};
			if (fb) a = a ^ 16'h1021;
		end
		return a;
	endfunction

	function automatic res_t make_result(logic sv, logic [7:0] mosi, logic desel,
		logic [7:0] rx, logic [1:0] kind, logic done, logic st);
		res_t o;
		o.mosi_byte      = sv ? mosi : 8'h00;
		o.send_valid     = sv;
		o.deselect_after = sv ? desel : 1'b0;
		o.rx_byte        = (kind != KindNone) ? rx : 8'h00;
		o.rx_kind        = kind;
		o.done_res       = done;
		o.status         = done ? st : 1'b0;
		return o;
	endfunction

	task automatic predict(req_t r);
		logic [7:0] m;
		logic [7:0] b;
		int unsigned rl;
		int unsigned bl;
		m = r.miso_byte;
		if (r.func == FuncStart) begin
			if (step == PH_IDLE) begin
				txn_op = (r.op == 2'd3) ? OpCmd : r.op;
				txn_index = r.cmd_index;
				txn_arg = r.argument;
				rl = r.resp_len;
				if (rl < 1) rl = 1;
				if (rl > 5) rl = 5;
				resp_left = (txn_op == OpCmd) ? rl - 1 : 0;
				bl = r.block_len;
				if (bl < 1) bl = 1;
				if (bl > MaxRead) bl = MaxRead;
				read_len = bl;
				crc16 = '0;
				npolls = 0;
				ticks = '0;
				b = {2'b01, txn_index};
				crc7 = crc7_next(7'h00, b);
				nbytes = 0;
				step = PH_FRAME;
				expected_q.push_back(make_result(1, b, 0, 0, KindNone, 0, 0));
			end
		end else if (r.func == FuncTick) begin
			if ((step == PH_TOKEN || step == PH_BUSY) && ticks != WaitMax) ticks++;
		end else if (r.func == FuncXfer) begin
			case (step)
				PH_FRAME: begin
					if (nbytes < 4) begin
						nbytes++;
						b = txn_arg[8*(4-nbytes) +: 8];
						crc7 = crc7_next(crc7, b);
						expected_q.push_back(make_result(1, b, 0, 0, KindNone, 0, 0));
					end else if (nbytes == 4) begin
						nbytes = 5;
						expected_q.push_back(make_result(1, {crc7, 1'b1}, 0, 0, KindNone, 0, 0));
					end else begin
						step = PH_R1;
						npolls = 1;
						expected_q.push_back(make_result(1, ByteIdle, 0, 0, KindNone, 0, 0));
					end
				end
				PH_R1: begin
					if (m[7] && npolls < Polls) begin
						npolls++;
						expected_q.push_back(make_result(1, ByteIdle, 0, 0, KindNone, 0, 0));
					end else if (txn_op == OpRead) begin
						if (m != 8'h00) begin
							step = PH_IDLE;
							expected_q.push_back(make_result(0, 0, 0, m, KindResp, 1, 1));
						end else begin
							step = PH_TOKEN;
							ticks = '0;
							expected_q.push_back(make_result(1, ByteIdle, 0, m, KindResp, 0, 0));
						end
					end else if (txn_op == OpWrite) begin
						step = PH_WSTART;
						expected_q.push_back(make_result(1, TokenStart, 0, m, KindResp, 0, 0));
					end else if (resp_left > 0) begin
						step = PH_RESP;
						expected_q.push_back(make_result(1, ByteIdle, 0, m, KindResp, 0, 0));
					end else begin
						step = PH_END_OK;
						expected_q.push_back(make_result(1, ByteIdle, 1, m, KindResp, 0, 0));
					end
				end
				PH_RESP: begin
					resp_left--;
					if (resp_left == 0) step = PH_END_OK;
					expected_q.push_back(make_result(1, ByteIdle, resp_left == 0, m,
						KindResp, 0, 0));
				end
				PH_END_OK, PH_END_ERR: begin
					expected_q.push_back(make_result(0, 0, 0, 0, KindNone, 1,
						step == PH_END_ERR));
					step = PH_IDLE;
				end
				PH_TOKEN: begin
					if (m == TokenStart) begin
						step = PH_RDATA;
						nbytes = 0;
						expected_q.push_back(make_result(1, ByteIdle, read_len == 1, 0,
							KindNone, 0, 0));
					end else if (m[7:4] == 4'h0) begin
						step = PH_IDLE;
						expected_q.push_back(make_result(0, 0, 0, m, KindResp, 1, 1));
					end else if (ticks >= token_limit) begin
						step = PH_IDLE;
						expected_q.push_back(make_result(0, 0, 0, 0, KindNone, 1, 1));
					end else begin
						expected_q.push_back(make_result(1, ByteIdle, 0, 0, KindNone, 0, 0));
					end
				end
				PH_RDATA: begin
					nbytes++;
					if (nbytes >= read_len) begin
						step = PH_IDLE;
						expected_q.push_back(make_result(0, 0, 0, m, KindData, 1, 0));
					end else begin
						expected_q.push_back(make_result(1, ByteIdle, nbytes + 1 == read_len,
							m, KindData, 0, 0));
					end
				end
				PH_WSTART: begin
					crc16 = crc16_next(16'h0000, r.write_byte);
					nbytes = 1;
					step = PH_WDATA;
					expected_q.push_back(make_result(1, r.write_byte, 0, 0, KindNone, 0, 0));
				end
				PH_WDATA: begin
					if (nbytes < WriteBytes) begin
						crc16 = crc16_next(crc16, r.write_byte);
						nbytes++;
						expected_q.push_back(make_result(1, r.write_byte, 0, 0, KindNone, 0, 0));
					end else begin
						step = PH_WCRC;
						nbytes = 0;
						expected_q.push_back(make_result(1, crc16[15:8], 0, 0, KindNone, 0, 0));
					end
				end
				PH_WCRC: begin
					if (nbytes == 0) begin
						nbytes = 1;
						expected_q.push_back(make_result(1, crc16[7:0], 0, 0, KindNone, 0, 0));
					end else begin
						step = PH_WRESP;
						npolls = 1;
						expected_q.push_back(make_result(1, ByteIdle, 0, 0, KindNone, 0, 0));
					end
				end
				PH_WRESP: begin
					if (m[4] && npolls < Polls) begin
						npolls++;
						expected_q.push_back(make_result(1, ByteIdle, 0, 0, KindNone, 0, 0));
					end else if (m[3:0] == DataAccepted) begin
						step = PH_BUSY;
						ticks = '0;
						expected_q.push_back(make_result(1, ByteIdle, 0, m, KindResp, 0, 0));
					end else begin
						step = PH_END_ERR;
						expected_q.push_back(make_result(1, ByteIdle, 1, m, KindResp, 0, 0));
					end
				end
				PH_BUSY: begin
					if (m != 8'h00 || ticks >= busy_limit) begin
						step = PH_END_OK;
						expected_q.push_back(make_result(1, ByteIdle, 1, 0, KindNone, 0, 0));
					end else begin
						expected_q.push_back(make_result(1, ByteIdle, 0, 0, KindNone, 0, 0));
					end
				end
				default: ;
			endcase
		end
	endtask

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
			got, want);
		fail_count++;
	endtask

	task automatic compare(res_t got);
		res_t want;
		if (expected_q.size() == 0) begin
			report("unexpected result", 32'(got), 32'(0));
			return;
		end
		want = expected_q.pop_front();
		if (got.mosi_byte != want.mosi_byte) report("mosi_byte", 32'(got.mosi_byte),
			32'(want.mosi_byte));
		if (got.send_valid != want.send_valid) report("send_valid", 32'(got.send_valid),
			32'(want.send_valid));
		if (got.deselect_after != want.deselect_after) report("deselect_after",
			32'(got.deselect_after), 32'(want.deselect_after));
		if (got.rx_byte != want.rx_byte) report("rx_byte", 32'(got.rx_byte),
			32'(want.rx_byte));
		if (got.rx_kind != want.rx_kind) report("rx_kind", 32'(got.rx_kind),
			32'(want.rx_kind));
		if (got.done_res != want.done_res) report("done_res", 32'(got.done_res),
			32'(want.done_res));
		if (got.status != want.status) report("status", 32'(got.status), 32'(want.status));
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_limit = TokenWaitReset;
			busy_limit = BusyWaitReset;
			step = PH_IDLE;
			txn_op = OpCmd;
			txn_index = '0;
			txn_arg = '0;
			nbytes = 0;
			npolls = 0;
			ticks = '0;
			crc7 = '0;
			crc16 = '0;
			resp_left = 0;
			read_len = 0;
		end else begin
			if (res_valid && res_ready) compare(res_data);
			if (req_valid && req_ready) predict(req_data);
			if (psel && penable && pwrite && pready) begin
				if (paddr == RegTokenWait) token_limit = pwdata[WaitW-1:0];
				else if (paddr == RegBusyWait) busy_limit = pwdata[WaitW-1:0];
			end
			pending = expected_q.size();
		end
	end

endmodule

/* verif/sd_spi_host_transaction_engine_tb.sv */
// ----------------------------------------------------------------------------
// sd_spi_host_transaction_engine_tb
// Plays the part of an SD card and its host against the engine: command,
// block read and block write transactions with random card answers, polls,
// timer ticks and stray requests, over several wait limit settings.
// ----------------------------------------------------------------------------
module sd_spi_host_transaction_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ssh_pkg::*;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int fail_count;
	int pending;
	int requests_sent;
	bit quiet;
	logic [WaitW-1:0] token_limit;
	logic [WaitW-1:0] busy_limit;

	ssh_stream_if #(.payload_t(req_t)) req_if ();
	ssh_stream_if #(.payload_t(res_t)) res_if ();

	sd_spi_host_transaction_engine i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	sd_spi_host_transaction_engine_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_if.valid),
		.req_ready  (req_if.ready),
		.req_data   (req_if.data),
		.res_valid  (res_if.valid),
		.res_ready  (res_if.ready),
		.res_data   (res_if.data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: ready with random stall bursts, none once the run goes quiet.
	initial begin
		res_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			res_if.ready <= 1'b1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	task automatic send(req_t r, bit counted);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do @(posedge clk); while (!req_if.ready);
		if (counted) requests_sent++;
	endtask

	function automatic req_t random_req(logic [1:0] func);
		req_t r;
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		r = raw[$bits(req_t)-1:0];
		r.func = func;
		return r;
	endfunction

	task automatic xfer(logic [7:0] miso);
		req_t r;
		r = random_req(FuncXfer);
		r.miso_byte = miso;
		send(r, 1);
	endtask

	task automatic ticks(int n);
		for (int i = 0; i < n; i++) send(random_req(FuncTick), 1);
	endtask

	// Requests the engine must ignore in the current phase.
	task automatic stray(bit in_frame);
		logic [1:0] f;
		f = 2'd3;
		case ($urandom_range(0, 2))
			0: f = in_frame ? FuncStart : FuncXfer;
			1: f = FuncTick;
			default: f = 2'd3;
		endcase
		send(random_req(f), 0);
	endtask

	task automatic quiesce();
		req_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_write(logic [AddrW-1:0] addr, logic [WaitW-1:0] value);
		wait (pending == 0);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {12'($urandom_range(0, 4095)), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (addr == RegTokenWait) token_limit = value;
		else busy_limit = value;
	endtask

	function automatic logic [7:0] not_token_byte();
		logic [7:0] b;
		do b = 8'($urandom()); while (b[7:4] == 4'h0 || b == TokenStart);
		return b;
	endfunction

	// Response polls: up to ResponsePollsDef - 1 bytes with the given bit set; the caller sends the answer.
	task automatic polls(int bit_pos, output int n);
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ResponsePollsDef - 1) : 0;
		for (int i = 0; i < n; i++) xfer(8'($urandom()) | (8'h01 << bit_pos));
	endtask

	task automatic transaction(logic [1:0] op, logic [5:0] idx, logic [31:0] arg,
		logic [2:0] rlen, logic [10:0] blen);
		req_t r;
		int n;
		int rl;
		int bl;
		int acc;
		int t;
		logic [7:0] r1;
		logic [7:0] ans;
		r = random_req(FuncStart);
		r.op = op;
		r.cmd_index = idx;
		r.argument = arg;
		r.resp_len = rlen;
		r.block_len = blen;
		send(r, 1);
		for (int i = 0; i < 6; i++) begin
			if ($urandom_range(0, 9) == 0) stray(1);
			xfer(8'($urandom()));
		end
		polls(7, n);
		r1 = 8'($urandom_range(0, 127));
		if (n == ResponsePollsDef - 1 && $urandom_range(0, 1)) r1 = 8'($urandom());
		if (op == OpRead && $urandom_range(0, 7) != 0) r1 = 8'h00;
		xfer(r1);
		if (op == OpRead) begin
			if (r1 != 8'h00) return;
			acc = 0;
			forever begin
				t = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
				ticks(t);
				acc += t;
				if (acc >= token_limit && $urandom_range(0, 1)) begin
					xfer(not_token_byte());
					return;
				end
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						xfer(not_token_byte());
						if (acc >= token_limit) return;
					end
					3: begin
						xfer({4'h0, 4'($urandom())});
						return;
					end
					default: begin
						if (acc >= token_limit) begin
							xfer(not_token_byte());
							return;
						end
						xfer(TokenStart);
						break;
					end
				endcase
			end
			bl = blen;
			if (bl < 1) bl = 1;
			if (bl > MaxReadBytesDef) bl = MaxReadBytesDef;
			for (int i = 0; i < bl; i++) xfer(8'($urandom()));
		end else if (op == OpWrite) begin
			for (int i = 0; i < WriteBlockBytesDef + 3; i++) xfer(8'($urandom()));
			polls(4, n);
			if ($urandom_range(0, 4) != 0) ans = {3'($urandom()), 1'b0, DataAccepted};
			else ans = {3'($urandom()), 1'b0, 4'($urandom())};
			if (n == ResponsePollsDef - 1 && $urandom_range(0, 1)) ans = 8'($urandom());
			xfer(ans);
			if (ans[3:0] == DataAccepted) begin
				acc = 0;
				forever begin
					t = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
					ticks(t);
					acc += t;
					if (acc >= busy_limit || $urandom_range(0, 2) == 0) begin
						xfer((acc >= busy_limit) ? 8'h00 : 8'($urandom_range(1, 255)));
						break;
					end
					xfer(8'h00);
				end
			end
			xfer(8'($urandom()));
		end else begin
			rl = rlen;
			if (rl < 1) rl = 1;
			if (rl > 5) rl = 5;
			for (int i = 0; i < rl; i++) xfer(8'($urandom()));
		end
	endtask

	task automatic random_transaction();
		logic [1:0] op;
		logic [10:0] blen;
		int p;
		p = $urandom_range(0, 99);
		if (p < 8) op = OpWrite;
		else if (p < 50) op = OpRead;
		else op = $urandom_range(0, 1) ? OpCmd : 2'd3;
		p = $urandom_range(0, 99);
		if (p < 1) blen = 11'($urandom_range(MaxReadBytesDef, 2047));
		else if (p < 5) blen = 0;
		else blen = 11'($urandom_range(1, 16));
		transaction(op, 6'($urandom()), $urandom(), 3'($urandom()), blen);
		if ($urandom_range(0, 3) == 0) stray(0);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		requests_sent = 0;
		quiet = 0;
		token_limit = TokenWaitReset;
		busy_limit = BusyWaitReset;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, op value 3 and out-of-range lengths.
		transaction(OpCmd, 6'd0, 32'h0000_0000, 3'd1, 11'd1);
		transaction(2'd3, 6'd63, 32'hFFFF_FFFF, 3'd0, 11'd0);
		transaction(OpCmd, 6'd8, 32'h0000_01AA, 3'd7, 11'd2047);
		transaction(OpRead, 6'd17, 32'h8000_0001, 3'd5, 11'd0);
		transaction(OpRead, 6'd18, 32'h1234_5678, 3'd2, 11'd3);
		stray(0);

		for (int ph = 0; ph < 5; ph++) begin
			quiesce();
			case (ph)
				1: begin
					reg_write(RegTokenWait, 20'd1);
					reg_write(RegBusyWait, 20'd1);
				end
				2: begin
					reg_write(RegTokenWait, WaitMax);
					reg_write(RegBusyWait, WaitMax);
				end
				3: begin
					reg_write(RegTokenWait, 20'($urandom_range(2, 12)));
					reg_write(RegBusyWait, 20'($urandom_range(2, 12)));
				end
				4: begin
					quiet = 1;
					reg_write(RegTokenWait, TokenWaitReset);
					reg_write(RegBusyWait, BusyWaitReset);
				end
				default: ;
			endcase
			while (requests_sent < (ph + 1) * 90) random_transaction();
		end
		quiesce();

		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
